/* hdl/case_folded_string_hash_bucket_macros.svh */
// Assertion helpers used by cfshb_ctrl.sv.
`ifndef CASE_FOLDED_STRING_HASH_BUCKET_MACROS_SVH
`define CASE_FOLDED_STRING_HASH_BUCKET_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFSHB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cfshb: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFSHB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cfshb: next-cycle check failed");

`endif

/* hdl/cfshb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cfshb_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned ACC_W  = 32;
    localparam int unsigned CNT_W  = $clog2(ACC_W);

    localparam logic [CHAR_W-1:0] CASE_FOLD_BIT = 8'h20;
    localparam logic [ACC_W-1:0]  POLY_MULT     = 32'd31;
    localparam logic [ACC_W-1:0]  BUCKETS_RESET = 32'd256;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic acc_update;
        logic div_start;
        logic div_step;
        logic out_load;
    } cmd_t;

endpackage

`default_nettype wire

/* hdl/cfshb_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface cfshb_in_if;
    import cfshb_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_byte;
    logic              string_end;

    modport source (output valid, output char_byte, output string_end, input ready);
    modport sink   (input valid, input char_byte, input string_end, output ready);
endinterface

`default_nettype wire

/* hdl/cfshb_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface cfshb_out_if;
    import cfshb_pkg::*;

    logic             valid;
    logic             ready;
    logic [ACC_W-1:0] bucket_index;

    modport source (output valid, output bucket_index, input ready);
    modport sink   (input valid, input bucket_index, output ready);
endinterface

`default_nettype wire

/* hdl/case_folded_string_hash_bucket.sv */
// Case-folded base-31 string hash reduced to a bucket index.
// in_ch carries one word per character: char_byte and string_end. A character
// word ORs 0x20 into the byte and updates acc = byte + 31 * acc (mod 2^32) in
// the cycle it is accepted; characters stream at one word per cycle while idle.
// A word with string_end set ignores its byte, clears the accumulator and
// starts a one-bit-per-cycle restoring division by bucket_count.
// out_ch carries bucket_index = acc mod bucket_count; a zero count passes the
// accumulator through. The result passes from the division steps through a
// hand-off state into the output register. in_ch.ready is low during both;
// the divider is the limiting unit. If the receiver stalls, the finished word
// waits in the output register and the block keeps taking characters; the
// next terminator's result waits in the hand-off stage until the register is
// free. cfg_wr_en/cfg_wr_data write bucket_count (reset value 256); the user
// must write bucket_count only while idle, as the block does not enforce it.
// Reset (rst_n low) clears the accumulator, empties the output register and
// restores bucket_count; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module case_folded_string_hash_bucket (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    cfshb_in_if.sink                         in_ch,
    cfshb_out_if.source                      out_ch,
    input  wire logic                        cfg_wr_en,
    input  wire logic [cfshb_pkg::ACC_W-1:0] cfg_wr_data
);
    import cfshb_pkg::*;

    cmd_t cmd;

    // Sequence the item: accept, divide, hand off, hold for the receiver.
    cfshb_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_ch.valid),
        .in_string_end (in_ch.string_end),
        .in_ready      (in_ch.ready),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .cmd           (cmd)
    );

    // Hold the accumulator, the bucket count, the divider and the output word.
    cfshb_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .char_byte    (in_ch.char_byte),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .bucket_index (out_ch.bucket_index)
    );

endmodule

`default_nettype wire

/* hdl/cfshb_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "case_folded_string_hash_bucket_macros.svh"

module cfshb_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_string_end,
    output logic                 in_ready,
    input  wire logic            out_ready,
    output logic                 out_valid,
    output cfshb_pkg::cmd_t      cmd
);
    import cfshb_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ACC_W - 1);

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.acc_update = accept && !in_string_end;
        cmd.div_start  = accept && in_string_end;
        cmd.div_step   = (state_reg == ST_DIV);
        cmd.out_load   = (state_reg == ST_DONE) && slot_free;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.div_start)
                begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Terminator launches a full-length division.
    `CFSHB_ASSERT_NEXT(a_start_div, clk, rst_n, accept && in_string_end, (state_reg == ST_DIV) && (cnt_reg == '0))
    // Last division step hands over to the output stage.
    `CFSHB_ASSERT_NEXT(a_div_done, clk, rst_n, (state_reg == ST_DIV) && (cnt_reg == CNT_LAST), state_reg == ST_DONE)
    // Never overwrite a word the receiver has not taken.
    `CFSHB_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_reg || out_ready)

endmodule

`default_nettype wire

/* hdl/cfshb_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module cfshb_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire cfshb_pkg::cmd_t              cmd,
    input  wire logic [cfshb_pkg::CHAR_W-1:0] char_byte,
    input  wire logic                         cfg_wr_en,
    input  wire logic [cfshb_pkg::ACC_W-1:0]  cfg_wr_data,
    output logic      [cfshb_pkg::ACC_W-1:0]  bucket_index
);
    import cfshb_pkg::*;

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  bucket_count_reg;
    logic [ACC_W-1:0]  rem_reg, rem_next;
    logic [ACC_W-1:0]  dvd_reg;
    logic [ACC_W-1:0]  bucket_index_reg;
    logic [CHAR_W-1:0] folded;
    logic [ACC_W-1:0]  acc_scaled;
    logic [ACC_W:0]    trial;

    assign folded     = char_byte | CASE_FOLD_BIT;
    assign acc_scaled = ACC_W'(acc_reg * POLY_MULT);

    always_comb
    begin
        priority if (cmd.div_start)
        begin
            acc_next = '0;
        end
        else if (cmd.acc_update)
        begin
            acc_next = acc_scaled + {{(ACC_W-CHAR_W){1'b0}}, folded};
        end
        else
        begin
            acc_next = acc_reg;
        end
    end

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    // With a zero bucket count every step subtracts nothing, so after the
    // full pass the remainder equals the dividend, which is the wanted result.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[ACC_W-1]};
        if (trial >= {1'b0, bucket_count_reg})
        begin
            rem_next = ACC_W'(trial - {1'b0, bucket_count_reg});
        end
        else
        begin
            rem_next = trial[ACC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg          <= '0;
            bucket_count_reg <= BUCKETS_RESET;
        end
        else
        begin
            acc_reg <= acc_next;
            if (cfg_wr_en)
            begin
                bucket_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            dvd_reg <= acc_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[ACC_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (cmd.out_load)
        begin
            bucket_index_reg <= rem_reg;
        end
    end

    assign bucket_index = bucket_index_reg;

endmodule

`default_nettype wire

/* test/bucket_index_checker.sv */
`timescale 1ns / 1ps

module bucket_index_checker
    import cfshb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [CHAR_W-1:0] in_char,
    input  logic              in_end,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [ACC_W-1:0]  out_bucket,
    input  logic              cfg_wr_en,
    input  logic [ACC_W-1:0]  cfg_wr_data,
    output int                buckets_owed,
    output int                mismatch_count
);

    logic [ACC_W-1:0] hash_acc;
    logic [ACC_W-1:0] bucket_count;
    logic [ACC_W-1:0] owed_buckets[$];
    logic [ACC_W-1:0] want_bucket;
    int               errors;

    // Fold case, then acc = byte + 31 * acc, wrapping at 32 bits.
    function automatic logic [ACC_W-1:0] fold_char(input logic [ACC_W-1:0] acc,
                                                   input logic [CHAR_W-1:0] c);
        logic [ACC_W-1:0] folded;
        folded = ACC_W'(c | CASE_FOLD_BIT);
        return folded + POLY_MULT * acc;
    endfunction

    // A zero count passes the accumulator through.
    function automatic logic [ACC_W-1:0] bucket_of(input logic [ACC_W-1:0] acc,
                                                   input logic [ACC_W-1:0] count);
        if (count == '0)
            return acc;
        return acc % count;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_acc       = '0;
            bucket_count   = BUCKETS_RESET;
            errors         = 0;
            owed_buckets.delete();
            buckets_owed   <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                bucket_count = cfg_wr_data;

            if (out_valid && out_ready)
            begin
                if (owed_buckets.size() == 0)
                begin
                    $display("%0t: unexpected bucket_index word: expected none, actual %h",
                             $time, out_bucket);
                    errors++;
                end
                else
                begin
                    want_bucket = owed_buckets.pop_front();
                    if (out_bucket !== want_bucket)
                    begin
                        $display("%0t: bucket_index mismatch: expected %h, actual %h",
                                 $time, want_bucket, out_bucket);
                        errors++;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                if (in_end)
                begin
                    owed_buckets.push_back(bucket_of(hash_acc, bucket_count));
                    hash_acc = '0;
                end
                else
                    hash_acc = fold_char(hash_acc, in_char);
            end

            buckets_owed   <= owed_buckets.size();
            mismatch_count <= errors;
        end
    end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import cfshb_pkg::*;

    localparam int RESET_CYCLES  = 5;
    // Leave margin for the division and hand-off to finish before touching the register.
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 82;
    localparam int NUM_PHASES    = 7;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [ACC_W-1:0] cfg_wr_data;
    int               buckets_owed;
    int               mismatch_count;
    int               items_sent = 0;
    int               stall_cycles = 0;

    // Knobs that the stimulus sets for the word sender and the result receiver.
    bit tx_idle_en    = 1'b1;
    bit rx_idle_en    = 1'b1;
    bit long_hold_req = 1'b0;

    // Bucket count per random phase: extremes first, out-of-range zero, then ordinary values.
    // The entry for phase 5 is replaced by a random count.
    logic [ACC_W-1:0] phase_buckets [NUM_PHASES] = '{
        32'd1, 32'hFFFF_FFFF, 32'd0, 32'd7, 32'h8000_0000, 32'd0, BUCKETS_RESET
    };

    cfshb_in_if  in_ch ();
    cfshb_out_if out_ch ();

    case_folded_string_hash_bucket u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Predict and compare every bucket_index word beside the block.
    bucket_index_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_ch.valid),
        .in_ready       (in_ch.ready),
        .in_char        (in_ch.char_byte),
        .in_end         (in_ch.string_end),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .out_bucket     (out_ch.bucket_index),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .buckets_owed   (buckets_owed),
        .mismatch_count (mismatch_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Offer one word and hold it until the block takes it. Before the word,
    // optionally drop valid for a short burst. Returns at the accepting edge with
    // valid still high, so a following word goes out with no bubble.
    task automatic send_word(input logic [CHAR_W-1:0] c, input logic last);
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.char_byte  <= c;
        in_ch.string_end <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Mix letters of both cases, so folding gets exercised, with arbitrary bytes.
    function automatic logic [CHAR_W-1:0] random_char();
        logic [CHAR_W-1:0] offset;
        offset = CHAR_W'($urandom_range(0, 25));
        case ($urandom_range(0, 3))
            0:       return 8'h41 + offset;
            1:       return 8'h61 + offset;
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly short strings, some long enough to wrap many times, a few empty.
    function automatic int random_length();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 0;
        if (pick < 3)
            return $urandom_range(11, 40);
        return $urandom_range(1, 10);
    endfunction

    // Send a whole string: characters, then a terminator with a random (ignored) byte.
    task automatic send_string(input int len);
        repeat (len) send_word(random_char(), 1'b0);
        send_word(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    // Drop valid and hold off until every owed bucket has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (buckets_owed != 0)
            @(posedge clk);
    endtask

    // Drain, then let the divider finish any tail work before the block counts as idle.
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_buckets(input logic [ACC_W-1:0] count);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Result receiver: long hold when asked, short random stall bursts otherwise.
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (long_hold_req)
            begin
                // Hold ready low long enough for the output stage to back up into in_ch.
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 4) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Watchdog: give up after too many cycles in which no word moves anywhere.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_wr_en)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Stimulus and verdict.
    initial
    begin
        int               phase;
        int               phase_start;
        bit               paused;
        logic [ACC_W-1:0] count;

        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        in_ch.valid      = 1'b0;
        in_ch.char_byte  = '0;
        in_ch.string_end = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings under the reset bucket count.
        // Empty string: bucket 0, and the terminator's byte must not leak in.
        send_word(8'h41, 1'b1);
        // "Hi" and "hI" fold to the same hash; terminator bytes differ and are ignored.
        send_word(8'h48, 1'b0);
        send_word(8'h69, 1'b0);
        send_word(8'h00, 1'b1);
        send_word(8'h68, 1'b0);
        send_word(8'h49, 1'b0);
        send_word(8'hFF, 1'b1);
        // A zero byte is just a character (folds to 0x20); high bytes stay unsigned.
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'h00, 1'b1);
        // Back-to-back terminators: two empty strings queued behind the divider.
        send_word(8'h5A, 1'b1);
        send_word(8'hA5, 1'b1);
        // Run of 0xFF to push the accumulator through several wraps.
        repeat (8) send_word(8'hFF, 1'b0);
        send_word(8'h20, 1'b1);

        // Random phases, each under its own bucket count; register writes only when idle.
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle();
            count = (phase == 5) ? ACC_W'($urandom()) : phase_buckets[phase];
            write_buckets(count);

            // Stall the receiver for a long stretch while strings keep coming.
            if (phase == 3)
                long_hold_req = 1'b1;
            // Run the last phase at full rate on both sides.
            if (phase == NUM_PHASES - 1)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end

            phase_start = items_sent;
            paused      = 1'b0;
            while (items_sent - phase_start < PHASE_ITEMS)
            begin
                // Halfway through one phase, let the pipeline empty completely.
                if (phase == 4 && !paused && items_sent - phase_start >= PHASE_ITEMS / 2)
                begin
                    drain();
                    paused = 1'b1;
                end
                send_string(random_length());
            end
        end

        settle();
        if (mismatch_count == 0 && buckets_owed == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/cfshb_pkg.sv
hdl/cfshb_in_if.sv
hdl/cfshb_out_if.sv
hdl/cfshb_ctrl.sv
hdl/cfshb_datapath.sv
hdl/case_folded_string_hash_bucket.sv
test/bucket_index_checker.sv
test/testbench.sv
